[rtl/json_string_escaper_unit_assert.svh]
// ----------------------------------------------------------------------------
// JSON string escaper assertion macros
// Shared property forms for the concurrent checks of the escaper.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_UNIT_ASSERT_SVH
`define JSON_STRING_ESCAPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define JSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escaper check failed");

// Next-cycle implication, disabled while reset is high.
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escaper check failed");

`endif

[rtl/jse_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string escaper package
// Widths, character codes, the expansion record and the hex helpers.
// ----------------------------------------------------------------------------
package jse_pkg;

   localparam int MAX_BYTES  = 14;
   localparam int CHAR_BYTES = 12;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SLASH_ESC  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ASCII_ONLY = 1'd1;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_NONE   = 8'h00;

   localparam logic [20:0] CP_BS       = 21'h00005C;
   localparam logic [20:0] CP_QUOTE    = 21'h000022;
   localparam logic [20:0] CP_SLASH    = 21'h00002F;
   localparam logic [20:0] CP_BACKSP   = 21'h000008;
   localparam logic [20:0] CP_FORMFEED = 21'h00000C;
   localparam logic [20:0] CP_NEWLINE  = 21'h00000A;
   localparam logic [20:0] CP_RETURN   = 21'h00000D;
   localparam logic [20:0] CP_TAB      = 21'h000009;
   localparam logic [20:0] CP_CTRL_LIM = 21'h000020;
   localparam logic [20:0] CP_ASCII_MAX = 21'h00007F;
   localparam logic [20:0] CP_TWO_BYTE = 21'h000800;
   localparam logic [20:0] CP_ONE_BYTE = 21'h000080;
   localparam logic [20:0] CP_SUPP     = 21'h010000;
   localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;

   localparam logic [15:0] HI_SURR_BASE = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] data;
      logic [CNT_W-1:0]          count;
      logic                      bad;
   } expand_type;

   function automatic byte_type hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end
      return 8'h37 + {4'h0, nib};
   endfunction

   // Backslash, 'u' and four uppercase hex digits; element 0 goes out first.
   function automatic logic [5:0][7:0] u16_escape(input logic [15:0] val);
      logic [5:0][7:0] r;
      r[0] = CH_BSLASH;
      r[1] = CH_U;
      r[2] = hex_char(val[15:12]);
      r[3] = hex_char(val[11:8]);
      r[4] = hex_char(val[7:4]);
      r[5] = hex_char(val[3:0]);
      return r;
   endfunction

   // Second character of a short escape, or CH_NONE where there is none.
   function automatic byte_type named_escape(input logic [20:0] cp);
      byte_type r;
      r = CH_NONE;
      if (cp == CP_BS)       r = CH_BSLASH;
      if (cp == CP_QUOTE)    r = CH_QUOTE;
      if (cp == CP_BACKSP)   r = CH_B;
      if (cp == CP_FORMFEED) r = CH_F;
      if (cp == CP_NEWLINE)  r = CH_N;
      if (cp == CP_RETURN)   r = CH_R;
      if (cp == CP_TAB)      r = CH_T;
      if (cp == CP_SLASH)    r = CH_SLASH;
      return r;
   endfunction

endpackage

[rtl/json_string_escaper_unit.sv]
// ----------------------------------------------------------------------------
// JSON string escaper
// Escapes one code point per item into JSON string text, one byte per result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | code_point, has_char, opens, closes
//  rsp     | out       | rsp_valid/ready   | out_byte, last_of_item, bad_char
//  csr     | in        | csr_write_en      | csr_index, csr_wdata
//
// An item is held in the input register, then its bytes are loaded into a
// shift buffer and leave one per cycle, while rsp_ready is high, at its head.
// With rsp_ready high, throughput is one item per cycle for one-byte items;
// an item of up to 14 bytes holds the buffer until its last byte leaves, so
// the output port sets the rate. Items with no bytes are dropped at the load.
// Reset is synchronous and clears the configuration and all valid state;
// backpressure stalls the buffer, then the input register, then req_ready.
// ----------------------------------------------------------------------------
module json_string_escaper_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [20:0]                    req_code_point,
   input  logic                           req_has_char,
   input  logic                           req_opens,
   input  logic                           req_closes,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last_of_item,
   output logic                           rsp_bad_char,
   input  logic                           csr_write_en,
   input  logic [jse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic                           csr_wdata
);
   import jse_pkg::*;

   logic                       esc_slash_ff;
   logic                       ens_ascii_ff;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic [20:0]                s1_cp_ff;
   logic                       s1_has_ff;
   logic                       s1_opens_ff;
   logic                       s1_closes_ff;
   logic [MAX_BYTES-1:0][7:0]  buf_ff;
   logic [MAX_BYTES-1:0][7:0]  buf_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic                       bad_ff;
   logic                       bad_in;
   logic                       load_ok;
   logic                       pop;
   logic                       req_take;
   expand_type                 expanded;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_slash_ff <= 1'b0;
         ens_ascii_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SLASH_ESC:  esc_slash_ff <= csr_wdata;
            CSR_ASCII_ONLY: ens_ascii_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The buffer can take a new item when empty or when its last byte leaves.
   assign pop      = rsp_valid && rsp_ready;
   assign load_ok  = (cnt_ff == '0) || (cnt_ff == 4'd1 && rsp_ready);
   assign req_ready = !s1_valid_ff || load_ok;
   assign req_take = req_valid && req_ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !load_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cp_ff     <= req_code_point;
         s1_has_ff    <= req_has_char;
         s1_opens_ff  <= req_opens;
         s1_closes_ff <= req_closes;
      end
   end

   jse_expand u_expand (
      .code_point   (s1_cp_ff),
      .has_char     (s1_has_ff),
      .opens        (s1_opens_ff),
      .closes       (s1_closes_ff),
      .slash_esc    (esc_slash_ff),
      .ascii_esc    (ens_ascii_ff),
      .result       (expanded)
   );

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      bad_in = bad_ff;
      priority if (s1_valid_ff && load_ok) begin
         buf_in = expanded.data;
         cnt_in = expanded.count;
         bad_in = expanded.bad;
      end else if (pop) begin
         buf_in = {8'h00, buf_ff[MAX_BYTES-1:1]};
         cnt_in = cnt_ff - 4'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      bad_ff <= bad_in;
   end

   assign rsp_valid        = cnt_ff != '0;
   assign rsp_out_byte     = buf_ff[0];
   assign rsp_last_of_item = cnt_ff == 4'd1;
   assign rsp_bad_char     = bad_ff;

`include "json_string_escaper_unit_assert.svh"

   `JSE_ASSERT_IMPL(a_bad_single, clock, reset, rsp_valid && rsp_bad_char,
                    rsp_last_of_item && rsp_out_byte == 8'h00)
   `JSE_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_BYTES))
   `JSE_ASSERT_NEXT(a_pop_steps, clock, reset, pop && cnt_ff > 4'd1,
                    cnt_ff == $past(cnt_ff) - 4'd1)
   `JSE_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !load_ok,
                    s1_valid_ff && $stable(s1_cp_ff))

endmodule

[rtl/jse_expand.sv]
// ----------------------------------------------------------------------------
// JSON string escaper expansion
// Turns one registered item into its full byte sequence, count and error flag.
// ----------------------------------------------------------------------------
module jse_expand (
   input  logic [20:0]          code_point,
   input  logic                 has_char,
   input  logic                 opens,
   input  logic                 closes,
   input  logic                 slash_esc,
   input  logic                 ascii_esc,
   output jse_pkg::expand_type  result
);
   import jse_pkg::*;

   logic [CHAR_BYTES-1:0][7:0] ch;
   logic [CNT_W-1:0]           nch;
   byte_type                   named;
   logic                       esc;
   logic                       bad;
   logic [20:0]                cp_off;
   logic [15:0]                hi_unit;
   logic [15:0]                lo_unit;

   assign bad = has_char &&
                ((code_point >= CP_SURR_LO && code_point <= CP_SURR_HI) ||
                 code_point > CP_MAX);

   assign esc = code_point == CP_BS || code_point == CP_QUOTE ||
                code_point < CP_CTRL_LIM ||
                (slash_esc && code_point == CP_SLASH) ||
                (ascii_esc && code_point > CP_ASCII_MAX);

   assign named   = named_escape(code_point);
   assign cp_off  = code_point - CP_SUPP;
   assign hi_unit = HI_SURR_BASE | {6'b0, cp_off[19:10]};
   assign lo_unit = LO_SURR_BASE | {6'b0, cp_off[9:0]};

   always_comb begin
      ch  = '0;
      nch = '0;
      priority if (!has_char) begin
         nch = '0;
      end else if (esc && named != CH_NONE) begin
         ch[0] = CH_BSLASH;
         ch[1] = named;
         nch   = 4'd2;
      end else if (esc && code_point < CP_SUPP) begin
         ch[5:0] = u16_escape(code_point[15:0]);
         nch     = 4'd6;
      end else if (esc) begin
         ch[5:0]  = u16_escape(hi_unit);
         ch[11:6] = u16_escape(lo_unit);
         nch      = 4'd12;
      end else if (code_point < CP_ONE_BYTE) begin
         ch[0] = code_point[7:0];
         nch   = 4'd1;
      end else if (code_point < CP_TWO_BYTE) begin
         ch[0] = {3'b110, code_point[10:6]};
         ch[1] = {2'b10, code_point[5:0]};
         nch   = 4'd2;
      end else if (code_point < CP_SUPP) begin
         ch[0] = {4'b1110, code_point[15:12]};
         ch[1] = {2'b10, code_point[11:6]};
         ch[2] = {2'b10, code_point[5:0]};
         nch   = 4'd3;
      end else begin
         ch[0] = {5'b11110, code_point[20:18]};
         ch[1] = {2'b10, code_point[17:12]};
         ch[2] = {2'b10, code_point[11:6]};
         ch[3] = {2'b10, code_point[5:0]};
         nch   = 4'd4;
      end
   end

   // The character bytes slide up by one slot when an opening quote leads.
   // Any slot past the character holds a quote, which only counts if closes.
   always_comb begin
      logic [CNT_W-1:0] rel;
      result = '0;
      for (int k = 0; k < MAX_BYTES; k++) begin
         rel = CNT_W'(k) - {{(CNT_W-1){1'b0}}, opens};
         if (opens && k == 0) begin
            result.data[k] = CH_QUOTE;
         end else if (rel < nch && rel < CNT_W'(CHAR_BYTES)) begin
            result.data[k] = ch[rel];
         end else begin
            result.data[k] = CH_QUOTE;
         end
      end
      result.count = {{(CNT_W-1){1'b0}}, opens} + nch + {{(CNT_W-1){1'b0}}, closes};
      result.bad   = bad;
      if (bad) begin
         result.data  = '0;
         result.count = 4'd1;
      end
   end

endmodule
